[rtl/isfc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isfc_pkg: shared types and constants
// Format codes, register indexes and the lane record that moves down the chain.
// ----------------------------------------------------------------------------
package isfc_pkg;

  localparam logic [1:0] FMT_F32 = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_S8  = 2'd2;
  localparam logic [1:0] FMT_BAD = 2'd3;

  localparam logic [1:0] REG_SRC  = 2'd0;
  localparam logic [1:0] REG_TGT  = 2'd1;
  localparam logic [1:0] REG_PREC = 2'd2;

  localparam logic [1:0] RST_SRC  = FMT_S16;
  localparam logic [1:0] RST_TGT  = FMT_F32;
  localparam logic [4:0] RST_PREC = 5'd12;

  // quotient bits: one integer bit and 26 fraction bits
  localparam int QBITS = 27;

  typedef enum logic [2:0] {
    M_ZERO,
    M_PASS,
    M_F2I,
    M_I2F,
    M_I2I
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic               sign;
    logic               zero;
    logic               tgt8;
    logic [31:0]        word;
    logic signed [6:0]  exp;
    logic [15:0]        dvsr;
    logic [16:0]        rem;
    logic [QBITS-1:0]   quo;
    logic [38:0]        prod;
    logic [7:0]         efld;
    logic               nan;
    logic               inf;
  } lane_t;

endpackage
`default_nettype wire

[rtl/iq_sample_format_converter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// iq_sample_format_converter: float32 / s16 / s8 sample component converter
// Decode stage, a chain of 27 division cells, and a rounding/saturation stage.
// ----------------------------------------------------------------------------
//  channel  ports                                            role
//  in       in_valid in_stall in_sample_in                   raw sample item
//  out      out_valid out_stall out_sample_out out_clipped   converted item + clip
//  cfg      cfg_wr_en cfg_index cfg_data                     format and precision regs
//
// One item per cycle sustained while out_stall is low; an accepted item
// passes the decode register, 27 division cells (one quotient bit per
// cell) and the output register on its way to out_valid.
// Every stage holds its item under stall and empty stages fill, so bubbles
// collapse. Synchronous active-low reset clears all valid bits, presets the regs.
module iq_sample_format_converter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_sample_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_sample_out,
  output logic             out_clipped,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);
  import isfc_pkg::*;

  logic [1:0]  src_r, tgt_r;
  logic [4:0]  prec_r;
  logic        in_ready;
  logic        v    [0:QBITS];
  logic        rdy  [0:QBITS];
  lane_t       lane [0:QBITS];
  logic        out_valid_r, out_clipped_r, back_ready, clip_nxt;
  logic [31:0] out_word_r, word_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r  <= RST_SRC;
      tgt_r  <= RST_TGT;
      prec_r <= RST_PREC;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SRC:  src_r  <= cfg_data[1:0];
        REG_TGT:  tgt_r  <= cfg_data[1:0];
        REG_PREC: prec_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  assign in_stall = !in_ready;

  isfc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .up_valid(in_valid), .up_ready(in_ready), .raw(in_sample_in),
    .src(src_r), .tgt(tgt_r), .prec(prec_r),
    .dn_valid(v[0]), .dn_ready(rdy[0]), .dn_lane(lane[0])
  );

  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    isfc_div_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .up_valid(v[i]), .up_ready(rdy[i]), .up_lane(lane[i]),
      .dn_valid(v[i+1]), .dn_ready(rdy[i+1]), .dn_lane(lane[i+1])
    );
  end

  isfc_back u_back (
    .lane(lane[QBITS]), .word(word_nxt), .clip(clip_nxt)
  );

  assign back_ready = !out_valid_r || !out_stall;
  assign rdy[QBITS] = back_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (back_ready) begin
      out_valid_r <= v[QBITS];
    end
    if (back_ready && v[QBITS]) begin
      out_word_r    <= word_nxt;
      out_clipped_r <= clip_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_word_r;
  assign out_clipped    = out_clipped_r;

  a_front_free: assert property (@(posedge clk) disable iff (!rst_n)
    !v[0] |-> !in_stall) else $error("input stalled with empty decode stage");

  a_clip_mode: assert property (@(posedge clk) disable iff (!rst_n)
    v[QBITS] && lane[QBITS].mode != M_F2I |-> !clip_nxt)
    else $error("clip raised outside float to integer");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    v[QBITS] && !out_valid_r |=> out_valid)
    else $error("finished item not moved to output register");

  a_zero_mode: assert property (@(posedge clk) disable iff (!rst_n)
    v[QBITS] && lane[QBITS].mode == M_ZERO |-> word_nxt == 32'd0 && !clip_nxt)
    else $error("unsupported format gave nonzero result");

endmodule
`default_nettype wire

[rtl/isfc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isfc_front: decode stage
// Classifies the item, normalizes integer magnitude and divisor, forms M*S.
// ----------------------------------------------------------------------------
module isfc_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire logic [31:0]         raw,
  input  wire logic [1:0]          src,
  input  wire logic [1:0]          tgt,
  input  wire logic [4:0]          prec,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output isfc_pkg::lane_t          dn_lane
);
  import isfc_pkg::*;

  logic        v_r;
  lane_t       lane_r, lane_nxt;
  logic [4:0]  pc;
  logic [3:0]  k, dsh;
  logic [14:0] s;
  logic [16:0] v17, a17;
  logic [15:0] a, m;
  logic [4:0]  lz;
  logic [23:0] mm;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_lane  = lane_r;

  always_comb begin
    pc = (prec < 5'd2) ? 5'd2 : ((prec > 5'd16) ? 5'd16 : prec);
    k  = 4'(pc - 5'd1);
    s  = 15'((16'd1 << k) - 16'd1);
    dsh = 4'(5'd16 - {1'b0, k});

    v17 = (src == FMT_S16) ? {raw[15], raw[15:0]} : {{9{raw[7]}}, raw[7:0]};
    a17 = v17[16] ? 17'(-v17) : v17;
    a   = a17[15:0];
    lz  = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (a[i]) lz = 5'(15 - i);
    end
    m  = a << lz[3:0];
    mm = {(raw[30:23] != 8'd0), raw[22:0]};

    lane_nxt       = '0;
    lane_nxt.tgt8  = (tgt == FMT_S8);
    lane_nxt.dvsr  = {1'b0, s} << dsh;
    lane_nxt.rem   = {1'b0, m};
    lane_nxt.efld  = (raw[30:23] == 8'd0) ? 8'd1 : raw[30:23];
    lane_nxt.nan   = (raw[30:23] == 8'hff) && (raw[22:0] != 23'd0);
    lane_nxt.inf   = (raw[30:23] == 8'hff) && (raw[22:0] == 23'd0);
    lane_nxt.prod  = {15'd0, mm} * {24'd0, s};
    lane_nxt.exp   = $signed(7'd16 - {3'd0, k} - {2'd0, lz});

    if (src == FMT_BAD || tgt == FMT_BAD) begin
      lane_nxt.mode = M_ZERO;
    end else if (src == FMT_F32 && tgt == FMT_F32) begin
      lane_nxt.mode = M_PASS;
      lane_nxt.word = raw;
    end else if (src == FMT_F32) begin
      lane_nxt.mode = M_F2I;
      lane_nxt.sign = raw[31];
    end else if (tgt == FMT_F32) begin
      lane_nxt.mode = M_I2F;
      lane_nxt.sign = v17[16];
      lane_nxt.zero = (a == 16'd0);
    end else begin
      lane_nxt.mode = M_I2I;
      lane_nxt.word = (tgt == FMT_S16) ? {{16{v17[15]}}, v17[15:0]}
                                       : {{24{v17[7]}}, v17[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
    if (up_ready && up_valid) lane_r <= lane_nxt;
  end

endmodule
`default_nettype wire

[rtl/isfc_div_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isfc_div_cell: one restoring division step
// Develops one quotient bit of mantissa / divisor and hands the lane on.
// ----------------------------------------------------------------------------
module isfc_div_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire isfc_pkg::lane_t     up_lane,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output isfc_pkg::lane_t          dn_lane
);
  import isfc_pkg::*;

  logic        v_r;
  lane_t       lane_r, lane_nxt;
  logic        ge;
  logic [16:0] rs;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_lane  = lane_r;

  always_comb begin
    ge = (up_lane.rem >= {1'b0, up_lane.dvsr});
    rs = ge ? (up_lane.rem - {1'b0, up_lane.dvsr}) : up_lane.rem;
    lane_nxt     = up_lane;
    lane_nxt.rem = {rs[15:0], 1'b0};
    lane_nxt.quo = {up_lane.quo[QBITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
    if (up_ready && up_valid) lane_r <= lane_nxt;
  end

endmodule
`default_nettype wire

[rtl/isfc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isfc_back: result stage
// Rounds the quotient to float32 or truncates and saturates M*S to integer.
// ----------------------------------------------------------------------------
module isfc_back (
  input  wire isfc_pkg::lane_t  lane,
  output logic [31:0]           word,
  output logic                  clip
);
  import isfc_pkg::*;

  logic        q26, g, st, rnd;
  logic [23:0] mant;
  logic [8:0]  b9;
  logic [30:0] mag;
  logic [7:0]  sh;
  logic [38:0] t;
  logic [16:0] t17, lim;
  logic        big;

  always_comb begin
    q26  = lane.quo[QBITS-1];
    mant = q26 ? lane.quo[26:3] : lane.quo[25:2];
    g    = q26 ? lane.quo[2] : lane.quo[1];
    st   = (q26 ? (lane.quo[1:0] != 2'd0) : lane.quo[0]) || (lane.rem != 17'd0);
    rnd  = g && (st || mant[0]);
    b9   = 9'd127 + {{2{lane.exp[6]}}, lane.exp} - (q26 ? 9'd0 : 9'd1);
    mag  = {b9[7:0], mant[22:0]} + {30'd0, rnd};

    big = lane.inf || (lane.efld >= 8'd150);
    sh  = 8'd150 - lane.efld;
    t   = (sh >= 8'd40) ? 39'd0 : (lane.prod >> sh[5:0]);
    t17 = t[16:0];
    lim = lane.tgt8 ? (lane.sign ? 17'd129 : 17'd128)
                    : (lane.sign ? 17'd32769 : 17'd32768);

    word = 32'd0;
    clip = 1'b0;
    unique case (lane.mode)
      M_PASS, M_I2I: word = lane.word;
      M_I2F: word = lane.zero ? 32'd0 : {lane.sign, mag};
      M_F2I: begin
        if (lane.nan) begin
          clip = 1'b1;
        end else if (big || t[38:17] != 22'd0 || t17 >= lim) begin
          clip = 1'b1;
          word = lane.tgt8 ? (lane.sign ? 32'hffffff80 : 32'h0000007f)
                           : (lane.sign ? 32'hffff8000 : 32'h00007fff);
        end else begin
          word = lane.sign ? 32'(-{15'd0, t17}) : {15'd0, t17};
        end
      end
      default: word = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

[tb/sv/isfc_checker.sv]
// ----------------------------------------------------------------------------
// isfc_checker: scoreboard for the IQ sample format converter
// Tracks register writes, predicts each accepted item's converted word and
// clip flag, and compares results in order against the expected queue.
// ----------------------------------------------------------------------------
module isfc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_sample_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_sample_out,
  input  logic        out_clipped,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  import isfc_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic        clip;
  } conv_t;

  conv_t       conv_q[$];
  logic [1:0]  src_fmt;
  logic [1:0]  tgt_fmt;
  logic [4:0]  prec;

  function automatic logic signed [31:0] sext(logic [31:0] v, logic is8);
    return is8 ? {{24{v[7]}}, v[7:0]} : {{16{v[15]}}, v[15:0]};
  endfunction

  // float32 bits to real; infinities mapped to huge values, subnormals to 0
  function automatic real f32_to_real(logic [31:0] b);
    logic [10:0] e11;
    if (b[30:23] == 8'hFF) return b[31] ? -1.0e30 : 1.0e30;
    if (b[30:23] == 8'h00) return 0.0;
    e11 = {3'b000, b[30:23]} + 11'd896;
    return $bitstoreal({b[31], e11, b[22:0], 29'b0});
  endfunction

  // double to float32 with round to nearest even; inputs are normal or zero
  function automatic logic [31:0] real_to_f32(real d);
    logic [63:0] b;
    logic [30:0] mag;
    logic [28:0] rest;
    if (d == 0.0) return 32'h0;
    b = $realtobits(d);
    mag = {8'(b[62:52] - 11'd896), b[51:29]};
    rest = b[28:0];
    if (rest > 29'h1000_0000 || (rest == 29'h1000_0000 && mag[0])) mag = mag + 31'd1;
    return {b[63], mag};
  endfunction

  function automatic conv_t convert_sample(logic [1:0] src, logic [1:0] tgt,
                                           logic [4:0] p, logic [31:0] raw);
    conv_t r;
    int    pc;
    real   s;
    real   d;
    int    hi;
    int    lo;
    logic signed [31:0] v;
    r.word = '0;
    r.clip = 1'b0;
    pc = (p < 2) ? 2 : (p > 16) ? 16 : p;
    s = real'((1 << (pc - 1)) - 1);
    if (src > FMT_S8 || tgt > FMT_S8) begin
      r.word = '0;
    end else if (src == FMT_F32 && tgt == FMT_F32) begin
      r.word = raw;
    end else if (src == FMT_F32) begin
      hi = (tgt == FMT_S8) ? 127 : 32767;
      lo = -hi - 1;
      if (raw[30:23] == 8'hFF && raw[22:0] != 0) begin
        r.clip = 1'b1;
      end else begin
        d = f32_to_real(raw);
        if (s != 1.0) d = d * s;
        if (d >= real'(hi) + 1.0) begin
          v = hi;
          r.clip = 1'b1;
        end else if (d <= real'(lo) - 1.0) begin
          v = lo;
          r.clip = 1'b1;
        end else begin
          v = $rtoi(d);
        end
        r.word = v;
      end
    end else if (tgt == FMT_F32) begin
      d = real'(sext(raw, src == FMT_S8));
      if (s != 1.0) d = d / s;
      r.word = real_to_f32(d);
    end else begin
      v = sext(raw, src == FMT_S8);
      r.word = sext(v, tgt == FMT_S8);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    checked = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    conv_t want;
    if (!rst_n) begin
      src_fmt <= RST_SRC;
      tgt_fmt <= RST_TGT;
      prec    <= RST_PREC;
    end else begin
      if (in_valid && !in_stall)
        conv_q.push_back(convert_sample(src_fmt, tgt_fmt, prec, in_sample_in));
      if (out_valid && !out_stall) begin
        checked++;
        if (conv_q.size() == 0) begin
          report_mismatch("unexpected item", out_sample_out, 32'h0);
        end else begin
          want = conv_q.pop_front();
          if (out_sample_out !== want.word)
            report_mismatch("sample_out", out_sample_out, want.word);
          if (out_clipped !== want.clip)
            report_mismatch("clipped", {31'b0, out_clipped}, {31'b0, want.clip});
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SRC:  src_fmt <= cfg_data[1:0];
          REG_TGT:  tgt_fmt <= cfg_data[1:0];
          REG_PREC: prec    <= cfg_data;
          default: ;
        endcase
      end
    end
    pending = conv_q.size();
  end

endmodule

[tb/sv/tb_iq_sample_format_converter.sv]
// ----------------------------------------------------------------------------
// tb_iq_sample_format_converter: stimulus and verdict for the converter
// Steps through format/precision settings, sends directed edge values and
// random samples with random gaps and stalls, and reports the checker result.
// ----------------------------------------------------------------------------
module tb_iq_sample_format_converter;
  import isfc_pkg::*;

  localparam int LATENCY = 29;
  localparam int CYCLE_LIMIT = 300000;
  localparam int NUM_PHASES = 18;
  localparam int RAND_PER_PHASE = 20;
  // extra items in the hold-off phase, enough to fill the whole chain
  localparam int SQUEEZE_EXTRA = 40;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_sample_in;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_sample_out;
  logic        out_clipped;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [4:0]  cfg_data;
  int          fail_count;
  int          pending;
  int          checked;
  int          cycles;
  logic        squeeze;

  iq_sample_format_converter dut (.*);

  isfc_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off when squeeze is raised
  initial begin
    int k;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze) begin
        out_stall <= 1'b1;
        for (k = 0; k < 120; k++) @(negedge clk);
        out_stall <= 1'b0;
        wait (!squeeze);
      end else if ($urandom_range(0, 99) < 5) begin
        out_stall <= 1'b1;
        k = $urandom_range(5, 30);
        repeat (k) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 25);
      end
    end
  end

  logic [31:0] edge_vals[] = '{
    32'h0000_0000, 32'h8000_0000, 32'h0000_7FFF, 32'h0000_8000, 32'h0000_FFFF,
    32'h0000_007F, 32'h0000_0080, 32'hFFFF_FFFF, 32'h3F80_0000, 32'hBF80_0000,
    32'h3F00_0000, 32'h3F7F_FFFF, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
    32'hFF80_0001, 32'h0000_0001, 32'h4700_0000, 32'h46FF_FE00, 32'hC700_0000,
    32'hC3000000, 32'h42FE_0000, 32'h7F7F_FFFF, 32'hAAAA_5555};

  // src, tgt, precision per phase; phase 0 keeps the reset values
  logic [1:0] ph_src[NUM_PHASES]  = '{FMT_S16, FMT_F32, FMT_F32, FMT_S8, FMT_S16, FMT_F32,
                                      FMT_F32, FMT_S16, FMT_S16, FMT_S8, FMT_F32, FMT_BAD,
                                      FMT_F32, FMT_S8, FMT_F32, FMT_S16, FMT_S8, FMT_F32};
  logic [1:0] ph_tgt[NUM_PHASES]  = '{FMT_F32, FMT_S16, FMT_S8, FMT_F32, FMT_F32, FMT_S16,
                                      FMT_S8, FMT_F32, FMT_S8, FMT_S16, FMT_F32, FMT_F32,
                                      FMT_BAD, FMT_F32, FMT_S16, FMT_S16, FMT_S8, FMT_S16};
  logic [4:0] ph_prec[NUM_PHASES] = '{12, 12, 8, 8, 16, 16, 2, 2, 5, 5, 12, 12, 31, 0, 1,
                                      17, 12, 16};

  task automatic send_sample(logic [31:0] v);
    int gap;
    if ($urandom_range(0, 99) < 30) begin
      @(negedge clk);
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] random_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: return r;
      // floats near the useful range
      1: return {r[31], 8'($urandom_range(100, 150)), r[22:0]};
      2: return {r[31], 8'($urandom_range(118, 127)), r[22:0]};
      default: return {{16{r[15]}}, r[15:0]};
    endcase
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_in = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_SRC;
    cfg_data = '0;
    squeeze = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        wait_drained();
        write_reg(REG_SRC, {3'b0, ph_src[ph]});
        write_reg(REG_TGT, {3'b0, ph_tgt[ph]});
        write_reg(REG_PREC, ph_prec[ph]);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
      end
      if (ph == 0 || ph == 1 || ph == 2)
        foreach (edge_vals[i]) send_sample(edge_vals[i]);
      if (ph == NUM_PHASES - 1) squeeze = 1'b1;
      for (int i = 0; i < RAND_PER_PHASE + ((ph == NUM_PHASES - 1) ? SQUEEZE_EXTRA : 0);
           i++)
        send_sample(random_sample());
      squeeze = 1'b0;
    end

    wait_drained();
    $display("covered %0d settings of source/target format and precision", NUM_PHASES);
    $display("%0d results compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/isfc_pkg.sv
rtl/isfc_front.sv
rtl/isfc_div_cell.sv
rtl/isfc_back.sv
rtl/iq_sample_format_converter.sv
tb/sv/isfc_checker.sv
tb/sv/tb_iq_sample_format_converter.sv
